// File: hdl/cptb_pkg.sv
// ----------------------------------------------------------------------------
// cptb_pkg
// Shared types, constants and helpers for the cascading prescaled timer bank.
// ----------------------------------------------------------------------------
package cptb_pkg;

  // Bank geometry
  localparam int NUM_TIMERS = 4;
  localparam int COUNT_BITS = 16;
  localparam int PSC_BITS   = 10;

  // Transaction opcodes
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WR_CTRL   = 2'd1,
    OP_WR_RELOAD = 2'd2,
    OP_RD_COUNT  = 2'd3
  } cptb_op_t;

  // Control word bit positions
  localparam int CTRL_PSC_LSB = 0;
  localparam int CTRL_CASCADE = 2;
  localparam int CTRL_IRQ_EN  = 6;
  localparam int CTRL_ENABLE  = 7;

  // Prescaler select codes
  localparam logic [1:0] PSC_DIV1    = 2'd0;
  localparam logic [1:0] PSC_DIV64   = 2'd1;
  localparam logic [1:0] PSC_DIV256  = 2'd2;
  localparam logic [1:0] PSC_DIV1024 = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  timer_index;
    logic [15:0] write_data;
  } cptb_in_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  overflow_pulses;
    logic [3:0]  irq_pulses;
  } cptb_out_t;

  // Command broadcast to every timer slice
  typedef struct packed {
    logic        tick;
    logic        wr_ctrl;
    logic        wr_reload;
    logic [15:0] data;
  } cptb_cmd_t;

  // Status returned by a timer slice
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
    logic                  irq;
  } cptb_stat_t;

  // Prescaler period for a select code
  function automatic logic [PSC_BITS:0] psc_period(input logic [1:0] sel);
    logic [PSC_BITS:0] p;
    case (sel)
      PSC_DIV1:    p = (PSC_BITS+1)'(1);
      PSC_DIV64:   p = (PSC_BITS+1)'(64);
      PSC_DIV256:  p = (PSC_BITS+1)'(256);
      PSC_DIV1024: p = (PSC_BITS+1)'(1024);
      default:     p = (PSC_BITS+1)'(1);
    endcase
    return p;
  endfunction

endpackage

// File: hdl/cptb_timer.sv
// ----------------------------------------------------------------------------
// cptb_timer
// One reload timer: control and reload registers, prescaler, up counter.
// ----------------------------------------------------------------------------
module cptb_timer
  import cptb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cptb_cmd_t  cmd,
  input  logic       sel,
  input  logic       carry_in,
  output cptb_stat_t stat
);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [PSC_BITS-1:0]   psc_cnt_r, psc_cnt_nxt;
  logic [1:0]            psc_sel_r, psc_sel_nxt;
  logic                  cascade_r, cascade_nxt;
  logic                  irq_en_r, irq_en_nxt;
  logic                  run_r, run_nxt;

  logic [PSC_BITS:0]     psc_inc;
  logic                  psc_hit;
  logic                  inc;
  logic                  wrap;

  // Prescaler step
  assign psc_inc = {1'b0, psc_cnt_r} + (PSC_BITS+1)'(1);
  assign psc_hit = (psc_inc >= psc_period(psc_sel_r));

  // Count enable: own prescaler or carry from the lower timer
  assign inc  = cmd.tick && run_r && (cascade_r ? carry_in : psc_hit);
  assign wrap = inc && (&count_r);

  // Next state
  always_comb begin
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    psc_cnt_nxt = psc_cnt_r;
    psc_sel_nxt = psc_sel_r;
    cascade_nxt = cascade_r;
    irq_en_nxt  = irq_en_r;
    run_nxt     = run_r;
    if (cmd.tick) begin
      if (run_r && !cascade_r) begin
        psc_cnt_nxt = psc_hit ? '0 : psc_inc[PSC_BITS-1:0];
      end
      if (inc) begin
        count_nxt = wrap ? reload_r : count_r + COUNT_BITS'(1);
      end
    end else if (sel && cmd.wr_ctrl) begin
      // load the count on a rising enable
      if (cmd.data[CTRL_ENABLE] && !run_r) begin
        count_nxt = reload_r;
      end
      psc_sel_nxt = cmd.data[CTRL_PSC_LSB +: 2];
      cascade_nxt = cmd.data[CTRL_CASCADE];
      irq_en_nxt  = cmd.data[CTRL_IRQ_EN];
      run_nxt     = cmd.data[CTRL_ENABLE];
      psc_cnt_nxt = '0;
    end else if (sel && cmd.wr_reload) begin
      reload_nxt = COUNT_BITS'(cmd.data);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      reload_r  <= '0;
      psc_cnt_r <= '0;
      psc_sel_r <= PSC_DIV1;
      cascade_r <= 1'b0;
      irq_en_r  <= 1'b0;
      run_r     <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      psc_cnt_r <= psc_cnt_nxt;
      psc_sel_r <= psc_sel_nxt;
      cascade_r <= cascade_nxt;
      irq_en_r  <= irq_en_nxt;
      run_r     <= run_nxt;
    end
  end

  // Status out; the overflow doubles as carry to the next timer
  assign stat.count = count_r;
  assign stat.ovf   = wrap;
  assign stat.irq   = wrap && irq_en_r;

endmodule

// File: hdl/cascading_prescaled_timer_bank.sv
// ----------------------------------------------------------------------------
// cascading_prescaled_timer_bank
// Bank of cascadable 16-bit reload timers with prescalers, driven by ticks
// and register accesses.
// ----------------------------------------------------------------------------
// Path: a transaction accepted at the input is held in the input register;
//   its result is then captured in the result register, raising out_valid.
// Throughput: one transaction per cycle unless the output stalls, set by the
//   single pass through the slices and the cascade between the two registers.
// Reset: rst_n clears all timer counts, reloads and controls and empties
//   both pipeline registers.
module cascading_prescaled_timer_bank
  import cptb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cptb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cptb_out_t out_data
);

  logic             s1_vld_r, s1_vld_nxt;
  cptb_in_t         s1_data_r;
  logic             out_vld_r, out_vld_nxt;
  cptb_out_t        out_data_r;
  logic             advance;

  cptb_cmd_t        cmd;
  cptb_stat_t       stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] carry;
  logic [NUM_TIMERS-1:0] ovf_vec;
  logic [NUM_TIMERS-1:0] irq_vec;
  logic [15:0]      rd_data;
  cptb_out_t        result;

  // Pipeline handshake
  assign advance    = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !s1_vld_r || advance;
  assign s1_vld_nxt = (in_valid && in_ready) || (s1_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Decode the held transaction into a command for the slices
  always_comb begin
    cmd.tick      = advance && (s1_data_r.op == OP_TICK);
    cmd.wr_ctrl   = advance && (s1_data_r.op == OP_WR_CTRL);
    cmd.wr_reload = advance && (s1_data_r.op == OP_WR_RELOAD);
    cmd.data      = s1_data_r.write_data;
  end

  // Timer slices with the cascade chain
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    assign sel[i] = (int'(s1_data_r.timer_index) == i);

    // the first timer has no lower neighbour to carry from
    if (i == 0) begin : g_first
      assign carry[i] = 1'b0;
    end else begin : g_chain
      assign carry[i] = stat[i-1].ovf;
    end

    cptb_timer u_tmr (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel[i]),
      .carry_in (carry[i]),
      .stat     (stat[i])
    );

    assign ovf_vec[i] = stat[i].ovf;
    assign irq_vec[i] = stat[i].irq;
  end

  // Read mux over the bank
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (sel[i] && (s1_data_r.op == OP_RD_COUNT)) begin
        rd_data = rd_data | 16'(stat[i].count);
      end
    end
  end

  always_comb begin
    result.read_data       = rd_data;
    result.overflow_pulses = 4'(ovf_vec);
    result.irq_pulses      = 4'(irq_vec);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // IRQ pulses only ever accompany overflows
  a_irq_in_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_data_r.irq_pulses & ~out_data_r.overflow_pulses) == 4'd0))
    else $error("irq pulse without overflow");

  // Register accesses never report overflows
  a_no_ovf_on_access: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_data_r.op != OP_TICK)) |=> (out_data_r.overflow_pulses == 4'd0))
    else $error("overflow reported on a register access");

  // Only reads return data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_data_r.op != OP_RD_COUNT)) |=> (out_data_r.read_data == 16'd0))
    else $error("nonzero read data on a non-read transaction");

  // Input stalls only when both registers are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without backpressure");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascading prescaled timer bank. A short table
// of directed transactions walks reload, enable, overflow and cascade corner
// cases. It is followed by weighted random traffic under several sender and
// receiver idling patterns, with one long receiver hold-off. Every result is
// compared field by field against a pinned result or an in-bench bank model.
// ----------------------------------------------------------------------------
module testbench;
  import cptb_pkg::*;

  localparam int PHASE_ITEMS  = 245;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 400_000;

  typedef enum int {
    PH_STEADY,
    PH_SPARSE_SEND,
    PH_SLOW_SINK,
    PH_MIXED,
    PH_BACKPRESSURE,
    PH_COUNT
  } phase_t;

  // One row of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    cptb_in_t  item;
    logic      pinned;
    cptb_out_t result;
  } timer_vec_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  cptb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  cptb_out_t out_data;

  // Model state of the timer bank
  logic [COUNT_BITS-1:0] tmr_count   [NUM_TIMERS];
  logic [COUNT_BITS-1:0] tmr_reload  [NUM_TIMERS];
  logic [PSC_BITS-1:0]   tmr_psc     [NUM_TIMERS];
  logic [1:0]            tmr_psc_sel [NUM_TIMERS];
  logic                  tmr_cascade [NUM_TIMERS];
  logic                  tmr_irq_en  [NUM_TIMERS];
  logic                  tmr_run     [NUM_TIMERS];

  cptb_out_t   pending_results [$];
  timer_vec_t  dir_table [$];
  int unsigned fail_count    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;

  cascading_prescaled_timer_bank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the model by one transaction and return the result it produces
  function automatic cptb_out_t timer_bank_step(input cptb_in_t item);
    cptb_out_t             res;
    logic                  carry;
    logic                  bump;
    logic [PSC_BITS:0]     phase;
    logic [PSC_BITS:0]     period;
    logic [COUNT_BITS-1:0] next_count;
    logic [1:0]            idx;
    res = '0;
    idx = item.timer_index;
    case (cptb_op_t'(item.op))
      OP_TICK: begin
        carry = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          bump = 1'b0;
          if (tmr_run[i]) begin
            if (tmr_cascade[i]) begin
              bump = carry;
            end else begin
              case (tmr_psc_sel[i])
                PSC_DIV64:   period = (PSC_BITS+1)'(64);
                PSC_DIV256:  period = (PSC_BITS+1)'(256);
                PSC_DIV1024: period = (PSC_BITS+1)'(1024);
                default:     period = (PSC_BITS+1)'(1);
              endcase
              phase = {1'b0, tmr_psc[i]} + 1'b1;
              if (phase >= period) begin
                phase = '0;
                bump  = 1'b1;
              end
              tmr_psc[i] = phase[PSC_BITS-1:0];
            end
          end
          // a wrap reloads the count and carries into the next timer
          carry = 1'b0;
          if (bump) begin
            next_count = tmr_count[i] + 1'b1;
            if (next_count == '0) begin
              next_count = tmr_reload[i];
              carry      = 1'b1;
              res.overflow_pulses[i] = 1'b1;
              if (tmr_irq_en[i]) res.irq_pulses[i] = 1'b1;
            end
            tmr_count[i] = next_count;
          end
        end
      end
      OP_WR_CTRL: begin
        // only a rising enable loads the reload value
        if (item.write_data[CTRL_ENABLE] && !tmr_run[idx]) tmr_count[idx] = tmr_reload[idx];
        tmr_psc_sel[idx] = item.write_data[CTRL_PSC_LSB +: 2];
        tmr_cascade[idx] = item.write_data[CTRL_CASCADE];
        tmr_irq_en[idx]  = item.write_data[CTRL_IRQ_EN];
        tmr_run[idx]     = item.write_data[CTRL_ENABLE];
        tmr_psc[idx]     = '0;
      end
      OP_WR_RELOAD: begin
        tmr_reload[idx] = item.write_data;
      end
      default: begin
        res.read_data = tmr_count[idx];
      end
    endcase
    return res;
  endfunction

  function automatic timer_vec_t vec(input cptb_op_t op, input logic [1:0] idx,
                                     input logic [15:0] data, input logic pinned,
                                     input logic [15:0] rd, input logic [3:0] ovf,
                                     input logic [3:0] irq);
    timer_vec_t v;
    v.item.op              = op;
    v.item.timer_index     = idx;
    v.item.write_data      = data;
    v.pinned               = pinned;
    v.result.read_data       = rd;
    v.result.overflow_pulses = ovf;
    v.result.irq_pulses      = irq;
    return v;
  endfunction

  // Offer one transaction from a falling edge; return at the falling edge
  // after it has been taken
  task automatic send_item(input cptb_in_t item, input logic pinned,
                           input cptb_out_t pinned_result);
    cptb_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = timer_bank_step(item);
    pending_results.push_back(pinned ? pinned_result : predicted);
    @(negedge clk);
  endtask

  // Result side: random stalls plus requested long hold-offs
  initial begin
    int unsigned asked;
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      asked = holds_asked;
      stall = sink_stall_pct;
      @(negedge clk);
      if (asked != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= stall);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    cptb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: %h", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data expected %h actual %h", want.read_data, out_data.read_data);
          fail_count++;
        end
        if (out_data.overflow_pulses !== want.overflow_pulses) begin
          $error("overflow_pulses expected %b actual %b",
                 want.overflow_pulses, out_data.overflow_pulses);
          fail_count++;
        end
        if (out_data.irq_pulses !== want.irq_pulses) begin
          $error("irq_pulses expected %b actual %b", want.irq_pulses, out_data.irq_pulses);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin
    cptb_in_t    item;
    timer_vec_t  row;
    int unsigned pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_count[i]   = '0;
      tmr_reload[i]  = '0;
      tmr_psc[i]     = '0;
      tmr_psc_sel[i] = '0;
      tmr_cascade[i] = 1'b0;
      tmr_irq_en[i]  = 1'b0;
      tmr_run[i]     = 1'b0;
    end

    dir_table = '{
      // reads and a tick straight after reset
      vec(OP_RD_COUNT,  2'd0, 16'h0000, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_RD_COUNT,  2'd3, 16'hFFFF, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b1, 16'h0000, 4'h0, 4'h0),
      // timer 0 near the top, rising enable loads it
      vec(OP_WR_RELOAD, 2'd0, 16'hFFFE, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_CTRL,   2'd0, 16'h00C0, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_RD_COUNT,  2'd0, 16'h0000, 1'b1, 16'hFFFE, 4'h0, 4'h0),
      vec(OP_TICK,      2'd2, 16'h1234, 1'b0, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b1, 16'h0000, 4'h1, 4'h1),
      // timer 1 cascades off timer 0 and wraps in the same tick
      vec(OP_WR_RELOAD, 2'd1, 16'hFFFF, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_CTRL,   2'd1, 16'h0084, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b0, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b1, 16'h0000, 4'h3, 4'h1),
      // disabled cascade target blocks the ripple to timer 3
      vec(OP_WR_RELOAD, 2'd2, 16'hFFFF, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_CTRL,   2'd2, 16'h0004, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_RELOAD, 2'd3, 16'h0000, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_CTRL,   2'd3, 16'h00C4, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd1, 16'h0000, 1'b0, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd3, 16'hFFFF, 1'b0, 16'h0000, 4'h0, 4'h0),
      // all control bits set: the first timer in cascade never counts
      vec(OP_WR_CTRL,   2'd0, 16'hFFFF, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_RD_COUNT,  2'd0, 16'h0000, 1'b0, 16'h0000, 4'h0, 4'h0),
      // falling enable freezes the count
      vec(OP_WR_CTRL,   2'd0, 16'h0000, 1'b1, 16'h0000, 4'h0, 4'h0),
      vec(OP_TICK,      2'd0, 16'h0000, 1'b0, 16'h0000, 4'h0, 4'h0),
      vec(OP_RD_COUNT,  2'd0, 16'h0000, 1'b0, 16'h0000, 4'h0, 4'h0),
      vec(OP_WR_CTRL,   2'd1, 16'h0041, 1'b0, 16'h0000, 4'h0, 4'h0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[r]) begin
      row = dir_table[r];
      send_item(row.item, row.pinned, row.result);
    end

    for (int ph = 0; ph < PH_COUNT; ph++) begin
      case (phase_t'(ph))
        PH_SPARSE_SEND: begin
          send_idle_pct  = 77;
          sink_stall_pct = 0;
        end
        PH_SLOW_SINK: begin
          send_idle_pct  = 0;
          sink_stall_pct = 77;
        end
        PH_MIXED: begin
          send_idle_pct  = 22;
          sink_stall_pct = 22;
        end
        PH_BACKPRESSURE: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
          holds_asked++;
        end
        default: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.timer_index = 2'($urandom_range(0, NUM_TIMERS - 1));
        item.write_data  = 16'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          item.op = OP_TICK;
        end else if (pick < 70) begin
          item.op = OP_RD_COUNT;
        end else if (pick < 82) begin
          // keep most reload values close to the wrap point
          item.op = OP_WR_RELOAD;
          if ($urandom_range(0, 99) < 80) item.write_data = 16'hFFFF - 16'($urandom_range(0, 31));
        end else begin
          item.op = OP_WR_CTRL;
          item.write_data[CTRL_ENABLE]  = ($urandom_range(0, 99) < 85);
          item.write_data[CTRL_CASCADE] = ($urandom_range(0, 99) < 35);
          if ($urandom_range(0, 99) < 60) item.write_data[CTRL_PSC_LSB +: 2] = PSC_DIV1;
        end
        send_item(item, 1'b0, '0);
      end
    end

    // drain the pipeline
    in_valid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
hdl/cptb_pkg.sv
hdl/cptb_timer.sv
hdl/cascading_prescaled_timer_bank.sv
tb/testbench.sv
